FILE: design/i2cts_pkg.sv
// ---------------------------------------------------------------------------
// I2C transaction sequencer package
// Shared codes, widths and the result group type used by all modules.
// ---------------------------------------------------------------------------
package i2cts_pkg;

  // Input operation codes.
  localparam logic [1:0] OpBegin = 2'd0;
  localparam logic [1:0] OpHost  = 2'd1;
  localparam logic [1:0] OpResp  = 2'd2;

  // Transaction modes.
  localparam logic [1:0] ModeRawWrite = 2'd0;
  localparam logic [1:0] ModeRawRead  = 2'd1;
  localparam logic [1:0] ModeRegWrite = 2'd2;
  localparam logic [1:0] ModeRegRead  = 2'd3;

  // Result kinds.
  localparam logic [2:0] KindStart   = 3'd0;
  localparam logic [2:0] KindRestart = 3'd1;
  localparam logic [2:0] KindStop    = 3'd2;
  localparam logic [2:0] KindSend    = 3'd3;
  localparam logic [2:0] KindRxAck   = 3'd4;
  localparam logic [2:0] KindRxNack  = 3'd5;
  localparam logic [2:0] KindData    = 3'd6;
  localparam logic [2:0] KindDone    = 3'd7;

  // Done status codes.
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusAddrNack = 2'd1;
  localparam logic [1:0] StatusByteNack = 2'd2;

  // Most results one input beat can cause.
  localparam int unsigned MaxResults = 3;

  // Default number of result groups held between front and back.
  localparam int unsigned QueueDepthDefault = 2;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_value;
    logic [1:0] status;
  } result_t;

  // All results caused by one accepted input beat.
  typedef struct packed {
    logic [1:0]                    count;
    result_t [MaxResults-1:0]      res;
  } group_t;

endpackage

FILE: design/i2cts_if.sv
// ---------------------------------------------------------------------------
// I2C transaction sequencer channel interfaces
// Valid/ready channels for the input beats and for the result beats.
// ---------------------------------------------------------------------------
interface i2cts_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [1:0] mode;
  logic [6:0] slave_address;
  logic [7:0] reg_count;
  logic [7:0] data_count;
  logic [7:0] tx_byte;
  logic       ack_received;
  logic [7:0] rx_byte;

  modport source (
    output valid, op, mode, slave_address, reg_count, data_count, tx_byte,
           ack_received, rx_byte,
    input  ready
  );
  modport sink (
    input  valid, op, mode, slave_address, reg_count, data_count, tx_byte,
           ack_received, rx_byte,
    output ready
  );
endinterface

interface i2cts_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] byte_value;
  logic [1:0] status;
  logic       last;

  modport source (output valid, kind, byte_value, status, last, input ready);
  modport sink   (input valid, kind, byte_value, status, last, output ready);
endinterface

FILE: design/i2cts_front.sv
// ---------------------------------------------------------------------------
// I2C transaction sequencer front end
// Accepts input beats, runs the transaction state and builds result groups.
// ---------------------------------------------------------------------------
module i2cts_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  i2cts_in_if.sink          in_i,
  input  logic              q_full_i,
  output logic              push_o,
  output i2cts_pkg::group_t grp_o
);

  localparam logic [3:0] PhIdle     = 4'd0;
  localparam logic [3:0] PhAddrAck  = 4'd1;
  localparam logic [3:0] PhWantReg  = 4'd2;
  localparam logic [3:0] PhRegAck   = 4'd3;
  localparam logic [3:0] PhAddr2Ack = 4'd4;
  localparam logic [3:0] PhWantData = 4'd5;
  localparam logic [3:0] PhDataAck  = 4'd6;
  localparam logic [3:0] PhRx       = 4'd7;

  logic [3:0] phase_q, phase_d;
  logic [1:0] mode_q, mode_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] regs_q, regs_d;
  logic [7:0] data_q, data_d;
  logic       accept;

  assign in_i.ready = ~q_full_i;
  assign accept     = in_i.valid & in_i.ready;

  always_comb begin
    logic [1:0] n;
    logic       go_after_regs;
    logic       go_data;
    logic       go_stop;
    logic       go_finish;
    logic [1:0] fin_status;

    n             = 2'd0;
    go_after_regs = 1'b0;
    go_data       = 1'b0;
    go_stop       = 1'b0;
    go_finish     = 1'b0;
    fin_status    = i2cts_pkg::StatusOk;
    grp_o         = '0;
    phase_d       = phase_q;
    mode_d        = mode_q;
    addr_d        = addr_q;
    regs_d        = regs_q;
    data_d        = data_q;

    case (in_i.op)
      i2cts_pkg::OpBegin: begin
        if (phase_q == PhIdle) begin
          mode_d = in_i.mode;
          addr_d = {in_i.slave_address, (in_i.mode == i2cts_pkg::ModeRawRead)};
          regs_d = in_i.mode[1] ? in_i.reg_count : 8'd0;
          data_d = in_i.data_count;
          grp_o.res[n] = '{i2cts_pkg::KindStart, 8'd0, i2cts_pkg::StatusOk};
          n = n + 2'd1;
          grp_o.res[n] = '{i2cts_pkg::KindSend, addr_d, i2cts_pkg::StatusOk};
          n = n + 2'd1;
          phase_d = PhAddrAck;
        end
      end
      i2cts_pkg::OpHost: begin
        if (phase_q == PhWantReg || phase_q == PhWantData) begin
          grp_o.res[n] = '{i2cts_pkg::KindSend, in_i.tx_byte, i2cts_pkg::StatusOk};
          n = n + 2'd1;
          phase_d = (phase_q == PhWantReg) ? PhRegAck : PhDataAck;
        end
      end
      i2cts_pkg::OpResp: begin
        case (phase_q)
          PhAddrAck: begin
            if (!in_i.ack_received) begin
              go_finish  = 1'b1;
              fin_status = i2cts_pkg::StatusAddrNack;
            end else if (mode_q[1]) begin
              if (regs_q != 8'd0) phase_d = PhWantReg;
              else                go_after_regs = 1'b1;
            end else begin
              go_data = 1'b1;
            end
          end
          PhRegAck: begin
            if (!in_i.ack_received) begin
              go_finish  = 1'b1;
              fin_status = i2cts_pkg::StatusByteNack;
            end else begin
              regs_d = regs_q - 8'd1;
              if (regs_d != 8'd0) phase_d = PhWantReg;
              else                go_after_regs = 1'b1;
            end
          end
          PhAddr2Ack: begin
            if (!in_i.ack_received) begin
              go_finish  = 1'b1;
              fin_status = i2cts_pkg::StatusAddrNack;
            end else begin
              go_data = 1'b1;
            end
          end
          PhDataAck: begin
            if (!in_i.ack_received) begin
              go_finish  = 1'b1;
              fin_status = i2cts_pkg::StatusByteNack;
            end else begin
              data_d = data_q - 8'd1;
              if (data_d != 8'd0) phase_d = PhWantData;
              else                go_stop = 1'b1;
            end
          end
          PhRx: begin
            grp_o.res[n] = '{i2cts_pkg::KindData, in_i.rx_byte, i2cts_pkg::StatusOk};
            n = n + 2'd1;
            data_d = data_q - 8'd1;
            if (data_d != 8'd0) begin
              grp_o.res[n] = '{(data_d == 8'd1) ? i2cts_pkg::KindRxNack
                                                : i2cts_pkg::KindRxAck,
                               8'd0, i2cts_pkg::StatusOk};
              n = n + 2'd1;
              phase_d = PhRx;
            end else begin
              go_stop = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    // Register read turns the bus around once the register bytes are out.
    if (go_after_regs) begin
      if (mode_q == i2cts_pkg::ModeRegRead) begin
        grp_o.res[n] = '{i2cts_pkg::KindRestart, 8'd0, i2cts_pkg::StatusOk};
        n = n + 2'd1;
        grp_o.res[n] = '{i2cts_pkg::KindSend, addr_q | 8'd1, i2cts_pkg::StatusOk};
        n = n + 2'd1;
        phase_d = PhAddr2Ack;
      end else begin
        go_data = 1'b1;
      end
    end

    if (go_data) begin
      if (data_d == 8'd0) begin
        go_stop = 1'b1;
      end else if (mode_q == i2cts_pkg::ModeRawWrite ||
                   mode_q == i2cts_pkg::ModeRegWrite) begin
        phase_d = PhWantData;
      end else begin
        grp_o.res[n] = '{(data_d == 8'd1) ? i2cts_pkg::KindRxNack
                                          : i2cts_pkg::KindRxAck,
                         8'd0, i2cts_pkg::StatusOk};
        n = n + 2'd1;
        phase_d = PhRx;
      end
    end

    if (go_stop) begin
      grp_o.res[n] = '{i2cts_pkg::KindStop, 8'd0, i2cts_pkg::StatusOk};
      n = n + 2'd1;
      go_finish  = 1'b1;
      fin_status = i2cts_pkg::StatusOk;
    end

    if (go_finish) begin
      grp_o.res[n] = '{i2cts_pkg::KindDone, 8'd0, fin_status};
      n = n + 2'd1;
      phase_d = PhIdle;
    end

    grp_o.count = n;
  end

  assign push_o = accept & (grp_o.count != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      mode_q  <= '0;
      addr_q  <= '0;
      regs_q  <= '0;
      data_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      mode_q  <= mode_d;
      addr_q  <= addr_d;
      regs_q  <= regs_d;
      data_q  <= data_d;
    end
  end

endmodule

FILE: design/i2cts_queue.sv
// ---------------------------------------------------------------------------
// I2C transaction sequencer group queue
// Small circular buffer of result groups between the front and back end.
// ---------------------------------------------------------------------------
module i2cts_queue #(
  parameter int unsigned Depth = i2cts_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  i2cts_pkg::group_t data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output i2cts_pkg::group_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  i2cts_pkg::group_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: design/i2cts_back.sv
// ---------------------------------------------------------------------------
// I2C transaction sequencer back end
// Streams head group results, one beat per cycle while out_o.ready is high.
// ---------------------------------------------------------------------------
module i2cts_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  i2cts_pkg::group_t head_i,
  output logic              pop_o,
  i2cts_out_if.source       out_o
);

  logic [1:0] idx_q;
  logic       is_last;
  logic       beat;

  assign is_last = (idx_q == head_i.count - 2'd1);
  assign beat    = out_o.valid & out_o.ready;
  assign pop_o   = beat & is_last;

  assign out_o.valid      = ~empty_i;
  assign out_o.kind       = head_i.res[idx_q].kind;
  assign out_o.byte_value = head_i.res[idx_q].byte_value;
  assign out_o.status     = head_i.res[idx_q].status;
  assign out_o.last       = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (beat) begin
      idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

FILE: design/i2c_transaction_sequencer.sv
// ---------------------------------------------------------------------------
// I2C transaction sequencer
// Sequences one I2C master transaction (raw or register read/write) over a
// byte-level bus engine, emitting bus commands, read data and a final status.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake      Payload
//   in_i     input      valid/ready    op, mode, slave_address, reg_count,
//                                      data_count, tx_byte, ack_received,
//                                      rx_byte
//   out_o    output     valid/ready    kind, byte_value, status, last
//
// The front end takes one input beat per cycle whenever the group queue has
// room, so a new beat can be accepted in the very next cycle. Each accepted
// beat that causes results pushes one group of one to three results; the
// back end sends one beat per cycle while out_o.ready is high, the first
// going out once its group heads the queue. Throughput is thus bounded by the
// output side at one result beat per cycle. A stalled output fills the
// queue (QueueDepth groups), after which in_i.ready drops. Reset clears the
// transaction state to idle and empties the queue; no clearing pass is needed.
// ---------------------------------------------------------------------------
module i2c_transaction_sequencer #(
  parameter int unsigned QueueDepth = i2cts_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  i2cts_in_if.sink   in_i,
  i2cts_out_if.source out_o
);

  // Front end: owns the transaction state and forms a result group per beat.
  logic              push;
  logic              q_full;
  logic              q_empty;
  logic              pop;
  i2cts_pkg::group_t grp;
  i2cts_pkg::group_t head;

  i2cts_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .grp_o    (grp)
  );

  // The queue lets the front keep accepting while results wait downstream.
  i2cts_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (grp),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // Back end: serializes the head group onto the result channel.
  i2cts_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  // A done beat always closes the group of the input beat that caused it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == i2cts_pkg::KindDone) |-> out_o.last)
    else $error("done beat not marked last");

  // A start is always followed by the address send in the same group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == i2cts_pkg::KindStart) |-> !out_o.last)
    else $error("start beat marked last");

  // Input back-pressure only arises when results are waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with nothing to send");

  // After a push, the output holds a valid beat in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_o.valid)
    else $error("pushed group not presented");

endmodule
